@@ src/cdnlhs_pkg.sv @@
// Shared types, constants and helper functions for the loop-tracking header scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdnlhs_pkg;

  localparam int MAX_HEADER_BYTES = 4096;
  localparam int MAX_ID_BYTES     = 16;
  localparam int COUNT_BITS       = 16;

  localparam int POS_W   = 13;
  localparam int IDX_W   = 5;
  localparam int LIT_W   = 3;
  localparam int STAT_W  = 10;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int OUT_W   = 72;

  localparam logic [POS_W-1:0]      MAX_POS   = POS_W'(MAX_HEADER_BYTES);
  localparam logic [IDX_W-1:0]      MAX_IDLEN = IDX_W'(MAX_ID_BYTES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LIT_W-1:0]      LIT_LAST  = 3'd6;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register addresses (8-byte stride, decoded on paddr[5:3])
  localparam logic [2:0] REG_ID_LOW    = 3'd0;
  localparam logic [2:0] REG_ID_HIGH   = 3'd1;
  localparam logic [2:0] REG_ID_LENGTH = 3'd2;
  localparam logic [2:0] REG_LIMIT     = 3'd3;
  localparam logic [2:0] REG_STATUS    = 3'd4;
  localparam logic [2:0] REG_CHECK_EN  = 3'd5;

  localparam logic [63:0] RST_ID_LOW    = 64'h7473_6572_6e65_706f;
  localparam logic [63:0] RST_ID_HIGH   = 64'h0000_0000_0000_0079;
  localparam logic [4:0]  RST_ID_LENGTH = 5'd9;
  localparam logic [15:0] RST_LIMIT     = 16'd10;
  localparam logic [9:0]  RST_STATUS    = 10'd508;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_ID,
    PH_LIT,
    PH_DIGITS,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [127:0]            id_bytes;
    logic [IDX_W-1:0]        id_length;
    logic [COUNT_BITS-1:0]   loop_limit;
    logic [STAT_W-1:0]       reject_status;
    logic                    check_enable;
  } cfg_t;

  typedef struct packed {
    logic                    match_found;
    logic [COUNT_BITS-1:0]   loop_count;
    logic [COUNT_BITS:0]     next_loop_count;
    logic                    reject;
    logic [STAT_W-1:0]       status_out;
    logic [POS_W-1:0]        span_start;
    logic [POS_W-1:0]        span_end;
  } res_t;

  function automatic logic [7:0] lower8(input logic [7:0] c);
    lower8 = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  // " loops=" literal that follows the semicolon
  function automatic logic [7:0] lit_char(input logic [LIT_W-1:0] k);
    case (k)
      3'd0:    lit_char = 8'h20;
      3'd1:    lit_char = 8'h6c;
      3'd2:    lit_char = 8'h6f;
      3'd3:    lit_char = 8'h6f;
      3'd4:    lit_char = 8'h70;
      3'd5:    lit_char = 8'h73;
      default: lit_char = 8'h3d;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ src/cdnlhs_cfg_regs.sv @@
// APB-style configuration register file for the header scanner.
// Depends on cdnlhs_pkg for register addresses, reset values and cfg_t.
`default_nettype none

module cdnlhs_cfg_regs
  import cdnlhs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output      logic [DATA_W-1:0] cfg_prdata,
  output      logic              cfg_pready,
  output      cfg_t              cfg_o
);

  logic [63:0]           id_low_r;
  logic [63:0]           id_high_r;
  logic [IDX_W-1:0]      id_len_r;
  logic [COUNT_BITS-1:0] limit_r;
  logic [STAT_W-1:0]     status_r;
  logic                  check_en_r;
  logic                  wr_en;
  logic [2:0]            reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_low_r   <= RST_ID_LOW;
      id_high_r  <= RST_ID_HIGH;
      id_len_r   <= RST_ID_LENGTH;
      limit_r    <= RST_LIMIT;
      status_r   <= RST_STATUS;
      check_en_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ID_LOW:    id_low_r   <= cfg_pwdata;
        REG_ID_HIGH:   id_high_r  <= cfg_pwdata;
        REG_ID_LENGTH: id_len_r   <= cfg_pwdata[IDX_W-1:0];
        REG_LIMIT:     limit_r    <= cfg_pwdata[COUNT_BITS-1:0];
        REG_STATUS:    status_r   <= cfg_pwdata[STAT_W-1:0];
        REG_CHECK_EN:  check_en_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ID_LOW:    cfg_prdata = id_low_r;
      REG_ID_HIGH:   cfg_prdata = id_high_r;
      REG_ID_LENGTH: cfg_prdata = DATA_W'(id_len_r);
      REG_LIMIT:     cfg_prdata = DATA_W'(limit_r);
      REG_STATUS:    cfg_prdata = DATA_W'(status_r);
      REG_CHECK_EN:  cfg_prdata = DATA_W'(check_en_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_o.id_bytes      = {id_high_r, id_low_r};
  assign cfg_o.id_length     = id_len_r;
  assign cfg_o.loop_limit    = limit_r;
  assign cfg_o.reject_status = status_r;
  assign cfg_o.check_enable  = check_en_r;

endmodule

`default_nettype wire

@@ src/cdnlhs_parser.sv @@
// Per-byte parser state machine: item splitting, id/literal/digit matching and
// end-of-header verdict. Depends on cdnlhs_pkg.
`default_nettype none

module cdnlhs_parser
  import cdnlhs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       valid_i,
  input  wire logic       last_i,
  input  wire cfg_t       cfg_i,
  output      res_t       res_o
);

  phase_t                phase_r, phase_nxt, ph_a, eff_ph;
  logic [POS_W-1:0]      pos_r, pos_nxt, pos_a;
  logic [POS_W-1:0]      ib_r, ib_nxt, ib_a;
  logic [IDX_W-1:0]      idx_r, idx_nxt, idx_a;
  logic [LIT_W-1:0]      lit_r, lit_nxt, lit_a;
  logic                  dig_r, dig_nxt, dig_a;
  logic                  trl_r, trl_nxt, trl_a;
  logic [COUNT_BITS-1:0] rc_r, rc_nxt, rc_a;
  logic                  fnd_r, fnd_nxt, fnd_a;
  logic [COUNT_BITS-1:0] fc_r, fc_nxt, fc_a;
  logic [POS_W-1:0]      fb_r, fb_nxt, fb_a;
  logic [POS_W-1:0]      fe_r, fe_nxt, fe_a;

  logic                  take, is_comma, is_space, is_semi, is_digit;
  logic                  active, start_item, len_ok, id_more, id_hit, lit_hit;
  logic                  close_c, close_e;
  logic [7:0]            c_low, id_ch;
  logic [COUNT_BITS+3:0] prod;
  logic [COUNT_BITS-1:0] rc_sat, cnt;

  assign take       = valid_i && (pos_r < MAX_POS);
  assign is_comma   = byte_i == CH_COMMA;
  assign is_space   = byte_i == CH_SPACE;
  assign is_semi    = byte_i == CH_SEMI;
  assign is_digit   = byte_i >= 8'h30 && byte_i <= 8'h39;
  assign c_low      = lower8(byte_i);
  assign active     = take && !is_comma && !fnd_r;
  assign start_item = active && phase_r == PH_LEAD && !is_space;
  assign eff_ph     = start_item ? PH_ID : phase_r;
  assign len_ok     = cfg_i.id_length != '0 && cfg_i.id_length <= MAX_IDLEN;
  assign id_more    = idx_r < cfg_i.id_length;
  assign id_ch      = cfg_i.id_bytes[{idx_r[3:0], 3'b000} +: 8];
  assign id_hit     = !is_semi && c_low == lower8(id_ch);
  assign lit_hit    = c_low == lit_char(lit_r);
  assign close_c    = take && is_comma && !fnd_r && phase_r == PH_DIGITS && dig_r;

  assign prod   = {4'b0, rc_r} * (COUNT_BITS+4)'(10) + (COUNT_BITS+4)'(byte_i[3:0]);
  assign rc_sat = (prod > {4'b0, COUNT_MAX}) ? COUNT_MAX : prod[COUNT_BITS-1:0];

  // next state of the parse phase
  always_comb begin
    ph_a = phase_r;
    if (take && is_comma) begin
      ph_a = PH_LEAD;
    end else if (active) begin
      unique case (eff_ph)
        PH_ID: begin
          if (!len_ok) begin
            ph_a = PH_FAIL;
          end else if (id_more) begin
            ph_a = id_hit ? PH_ID : PH_FAIL;
          end else begin
            ph_a = is_semi ? PH_LIT : PH_FAIL;
          end
        end
        PH_LIT: begin
          if (!lit_hit) begin
            ph_a = PH_FAIL;
          end else if (lit_r == LIT_LAST) begin
            ph_a = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (trl_r) ph_a = PH_FAIL;
          end else if (!(is_space && dig_r)) begin
            ph_a = PH_FAIL;
          end
        end
        default: ph_a = eff_ph;
      endcase
    end
    phase_nxt = last_i ? PH_LEAD : ph_a;
  end

  // datapath and verdict
  always_comb begin
    idx_a = idx_r;
    lit_a = lit_r;
    dig_a = dig_r;
    trl_a = trl_r;
    rc_a  = rc_r;
    if (take && is_comma) begin
      idx_a = '0;
      lit_a = '0;
      dig_a = 1'b0;
      trl_a = 1'b0;
      rc_a  = '0;
    end else if (active) begin
      case (eff_ph)
        PH_ID:     if (len_ok && id_more && id_hit) idx_a = idx_r + 1'b1;
        PH_LIT:    if (lit_hit) lit_a = lit_r + 1'b1;
        PH_DIGITS: begin
          if (is_digit && !trl_r) begin
            rc_a  = rc_sat;
            dig_a = 1'b1;
          end else if (is_space && dig_r) begin
            trl_a = 1'b1;
          end
        end
        default: ;
      endcase
    end

    ib_a  = start_item ? pos_r : ib_r;
    pos_a = take ? pos_r + 1'b1 : pos_r;
    fnd_a = fnd_r || close_c;
    fc_a  = close_c ? rc_r : fc_r;
    fb_a  = close_c ? ib_r : fb_r;
    fe_a  = close_c ? pos_r + 1'b1 : fe_r;

    // header end closes the open item
    close_e = !fnd_a && ph_a == PH_DIGITS && dig_a;
    cnt     = fnd_a ? fc_a : (close_e ? rc_a : '0);

    res_o.match_found     = fnd_a || close_e;
    res_o.loop_count      = cnt;
    res_o.next_loop_count = {1'b0, cnt} + 1'b1;
    res_o.reject          = cfg_i.check_enable && cnt > cfg_i.loop_limit;
    res_o.status_out      = res_o.reject ? cfg_i.reject_status : '0;
    res_o.span_start      = fnd_a ? fb_a : (close_e ? ib_a : '0);
    res_o.span_end        = fnd_a ? fe_a : (close_e ? pos_a : '0);

    if (last_i) begin
      pos_nxt = '0;
      ib_nxt  = '0;
      idx_nxt = '0;
      lit_nxt = '0;
      dig_nxt = 1'b0;
      trl_nxt = 1'b0;
      rc_nxt  = '0;
      fnd_nxt = 1'b0;
      fc_nxt  = '0;
      fb_nxt  = '0;
      fe_nxt  = '0;
    end else begin
      pos_nxt = pos_a;
      ib_nxt  = ib_a;
      idx_nxt = idx_a;
      lit_nxt = lit_a;
      dig_nxt = dig_a;
      trl_nxt = trl_a;
      rc_nxt  = rc_a;
      fnd_nxt = fnd_a;
      fc_nxt  = fc_a;
      fb_nxt  = fb_a;
      fe_nxt  = fe_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      pos_r   <= '0;
      ib_r    <= '0;
      idx_r   <= '0;
      lit_r   <= '0;
      dig_r   <= 1'b0;
      trl_r   <= 1'b0;
      rc_r    <= '0;
      fnd_r   <= 1'b0;
      fc_r    <= '0;
      fb_r    <= '0;
      fe_r    <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ib_r    <= ib_nxt;
      idx_r   <= idx_nxt;
      lit_r   <= lit_nxt;
      dig_r   <= dig_nxt;
      trl_r   <= trl_nxt;
      rc_r    <= rc_nxt;
      fnd_r   <= fnd_nxt;
      fc_r    <= fc_nxt;
      fb_r    <= fb_nxt;
      fe_r    <= fe_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/cdn_loop_header_scan.sv @@
// Top level of the loop-tracking header scanner: input register, parser, result register.
// Depends on cdnlhs_pkg, cdnlhs_cfg_regs and cdnlhs_parser.
//
// Header bytes enter one per transaction and the block takes a new one every
// cycle. Each byte goes through an input register and is parsed from there
// when it may advance. The verdict for a header is loaded into the output
// register by the same edge that parses its last transaction. Only a
// transaction with in_tlast set produces a result. Throughput is one byte per
// cycle, held back only when a finished result is still waiting on out_tready.
// Configuration is to be written over the APB-style port only while the stream
// is idle; the block itself does not enforce this. pready is always high.
`default_nettype none

module cdn_loop_header_scan
  import cdnlhs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] header_byte
  input  wire logic              in_tuser,   // [0] byte_valid
  input  wire logic              in_tlast,   // end_of_header
  // result stream
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  // [0] match_found, [16:1] loop_count, [33:17] next_loop_count, [34] reject,
  // [44:35] status_out, [57:45] span_start, [70:58] span_end, [71] zero
  output      logic [OUT_W-1:0]  out_tdata,
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output      logic [DATA_W-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_bvalid_r;
  logic       s1_last_r;
  logic       advance;
  logic       out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  cdnlhs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // a header end can only move on once the result register is free
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r   <= in_tdata;
      s1_bvalid_r <= in_tuser;
      s1_last_r   <= in_tlast;
    end
  end

  cdnlhs_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (advance),
    .byte_i  (s1_byte_r),
    .valid_i (s1_bvalid_r),
    .last_i  (s1_last_r),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_data_r <= {1'b0, res.span_end, res.span_start, res.status_out, res.reject,
                     res.next_loop_count, res.loop_count, res.match_found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ src/cdnlhs_checker.sv @@
// Port-level checker for the loop-tracking header scanner, bound to the top level.
// Depends on cdnlhs_pkg and cdn_loop_header_scan.
`default_nettype none

module cdnlhs_checker
  import cdnlhs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  logic                  match;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS:0]   cnt_next;
  logic                  rej;
  logic [STAT_W-1:0]     status;
  logic [POS_W-1:0]      sp_start;
  logic [POS_W-1:0]      sp_end;

  assign match    = out_tdata[0];
  assign cnt      = out_tdata[16:1];
  assign cnt_next = out_tdata[33:17];
  assign rej      = out_tdata[34];
  assign status   = out_tdata[44:35];
  assign sp_start = out_tdata[57:45];
  assign sp_end   = out_tdata[70:58];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_next == {1'b0, cnt} + 1'b1)
    else $error("next loop count is not count plus one");

  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !match |-> cnt == '0 && sp_start == '0 && sp_end == '0 && !rej)
    else $error("no-match result carries data");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && match |-> sp_start < sp_end)
    else $error("matched span is empty");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !rej |-> status == '0)
    else $error("status set without reject");

endmodule

bind cdn_loop_header_scan cdnlhs_checker u_cdnlhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
